### rtl/core/cci_pkg.sv
// Shared types and constants for the circle-circle intersection block.
// No dependencies; imported by the top level.
package cci_pkg;

  localparam int COORD_BITS  = 48;
  localparam int RATIO_FRAC  = 28;
  localparam int RATIO_BITS  = 31;
  localparam int FACTOR_BITS = 16;
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd9830;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_SAME_CENTER,
    STATUS_NO_CROSS,
    STATUS_WEAK
  } status_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_a_x;
    logic signed [COORD_BITS-1:0] center_a_y;
    logic signed [COORD_BITS-1:0] center_b_x;
    logic signed [COORD_BITS-1:0] center_b_y;
    logic        [COORD_BITS-2:0] radius_a;
    logic        [COORD_BITS-2:0] radius_b;
  } cci_req_t;

  typedef struct packed {
    logic        [1:0]            solution_count;
    status_e                      status_code;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } cci_res_t;

endpackage

### rtl/core/circle_circle_intersection.sv
// Circle-circle intersection, fully pipelined fixed-point datapath.
// Depends on cci_pkg and cci_isqrt.
//
// Usage:
//   Drive req_i and raise start; a transaction is taken at each rising edge
//   with start high and busy low. busy stays low: the pipeline advances every
//   cycle, so one transaction per cycle is accepted, back to back.
//   Each transaction yields exactly one result on res_o, shown for one cycle
//   with res_valid_o high. Its path runs through the distance square root (one
//   bit per stage), the 31-stage ratio divider and the 31-stage root of g.
//   The receiver cannot stall; results leave in acceptance order.
//   The weak-angle factor is written over the cfg channel (cfg_ready_o is
//   always high) and should only change while no transaction is in flight.
//   Reset clears all valid bits and loads the factor with 0.15 (9830);
//   no clearing pass is needed.
module circle_circle_intersection import cci_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  cci_req_t               req_i,
  output logic                   res_valid_o,
  output cci_res_t               res_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [FACTOR_BITS-1:0] cfg_data_i
);

  localparam int CB  = COORD_BITS;
  localparam int RB  = CB - 1;
  localparam int MW  = (CB + 1 > 63) ? 63 : CB + 1;   // |dx| width
  localparam int HW  = (MW + 1) / 2;
  localparam int UW  = MW - HW;
  localparam int RW  = MW + 1;                        // distance root bits
  localparam int SQW = 2 * RW;
  localparam int WB  = 66;
  localparam int RF  = RATIO_FRAC;
  localparam int QW  = RATIO_BITS;
  localparam int NW  = RB + RF;
  localparam int CW  = NW + RW;
  localparam int PRW = 2 * QW + 3;
  localparam int FW  = PRW - 29;
  localparam int TW  = 2 * QW - RF;
  localparam int GW  = TW;
  localparam int N2  = (GW + RF) / 2;
  localparam int FM  = QW + 1;
  localparam int PW  = MW + FM;
  localparam int MXW = (PW > WB) ? PW : WB;
  localparam int LAT = CB + 77;

  localparam logic signed [WB-1:0] LIM62  = WB'(64'sh4000_0000_0000_0000);
  localparam logic signed [WB-1:0] I64MAX = WB'(64'sh7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [WB-1:0] I64MIN = ~I64MAX;
  localparam logic signed [WB-1:0] CMAX   = (WB'(1) << (CB - 1)) - WB'(1);
  localparam logic signed [WB-1:0] CMIN   = ~CMAX;
  localparam logic [MXW-1:0]       LIMU   = MXW'(64'h4000_0000_0000_0000);
  localparam logic signed [PRW-1:0] HALF  = PRW'(64'h0100_0000_0000_0000);
  localparam logic [QW-1:0]        RATIO_MAX = {QW{1'b1}};

  typedef struct packed {
    logic                 same;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic                 sx;
    logic                 sy;
    logic [MW-1:0]        mx;
    logic [MW-1:0]        my;
  } ctx_t;

  typedef struct packed {
    ctx_t          ctx;
    logic [RB-1:0] ra;
    logic [RB-1:0] rb;
  } geo_t;

  typedef struct packed {
    ctx_t          ctx;
    logic          none;
    logic          fneg;
    logic [FM-1:0] fmag;
    logic [TW-1:0] thr;
    logic          gpos;
  } pt_t;

  typedef struct packed {
    logic [1:0] cnt;
    status_e    st;
  } sol_t;

  function automatic logic signed [WB-1:0] sat64(input logic signed [WB-1:0] v);
    if (v > I64MAX) return I64MAX;
    if (v < I64MIN) return I64MIN;
    return v;
  endfunction

  function automatic logic [CB-1:0] clampc(input logic signed [WB-1:0] v);
    logic signed [WB-1:0] c;
    c = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return c[CB-1:0];
  endfunction

  // ---------------- control ports ----------------
  logic [FACTOR_BITS-1:0] factor_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      factor_q <= cfg_data_i;
    end
  end

  // ---------------- A: input register ----------------
  logic     a_v_q;
  cci_req_t a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else         a_v_q <= start && !busy;
  end
  always_ff @(posedge clk_i) a_q <= req_i;

  // ---------------- B: center difference ----------------
  logic signed [WB-1:0] b_dxw, b_dyw, b_dxc, b_dyc, b_dxa, b_dya;
  geo_t                 b_geo_d, b_geo_q;
  logic                 b_v_q;

  always_comb begin
    b_dxw = WB'(a_q.center_b_x) - WB'(a_q.center_a_x);
    b_dyw = WB'(a_q.center_b_y) - WB'(a_q.center_a_y);
    b_dxc = (b_dxw > LIM62) ? LIM62 : ((b_dxw < -LIM62) ? -LIM62 : b_dxw);
    b_dyc = (b_dyw > LIM62) ? LIM62 : ((b_dyw < -LIM62) ? -LIM62 : b_dyw);
    b_dxa = b_dxc[WB-1] ? -b_dxc : b_dxc;
    b_dya = b_dyc[WB-1] ? -b_dyc : b_dyc;
    b_geo_d.ctx.same = (b_dxc == '0) && (b_dyc == '0);
    b_geo_d.ctx.ax   = a_q.center_a_x;
    b_geo_d.ctx.ay   = a_q.center_a_y;
    b_geo_d.ctx.sx   = b_dxc[WB-1];
    b_geo_d.ctx.sy   = b_dyc[WB-1];
    b_geo_d.ctx.mx   = b_dxa[MW-1:0];
    b_geo_d.ctx.my   = b_dya[MW-1:0];
    b_geo_d.ra       = a_q.radius_a;
    b_geo_d.rb       = a_q.radius_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else         b_v_q <= a_v_q;
  end
  always_ff @(posedge clk_i) b_geo_q <= b_geo_d;

  // ---------------- C: partial products of dx^2, dy^2 ----------------
  logic            c_v_q;
  geo_t            c_geo_q;
  logic [2*HW-1:0] c_xll_q, c_yll_q;
  logic [MW-1:0]   c_xlh_q, c_ylh_q;
  logic [2*UW-1:0] c_xhh_q, c_yhh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else         c_v_q <= b_v_q;
  end
  always_ff @(posedge clk_i) begin
    c_geo_q <= b_geo_q;
    c_xll_q <= b_geo_q.ctx.mx[HW-1:0] * b_geo_q.ctx.mx[HW-1:0];
    c_xlh_q <= b_geo_q.ctx.mx[HW-1:0] * b_geo_q.ctx.mx[MW-1:HW];
    c_xhh_q <= b_geo_q.ctx.mx[MW-1:HW] * b_geo_q.ctx.mx[MW-1:HW];
    c_yll_q <= b_geo_q.ctx.my[HW-1:0] * b_geo_q.ctx.my[HW-1:0];
    c_ylh_q <= b_geo_q.ctx.my[HW-1:0] * b_geo_q.ctx.my[MW-1:HW];
    c_yhh_q <= b_geo_q.ctx.my[MW-1:HW] * b_geo_q.ctx.my[MW-1:HW];
  end

  // ---------------- D: sum of squares ----------------
  logic           d_v_q;
  geo_t           d_geo_q;
  logic [SQW-1:0] d_rad_d, d_rad_q;

  assign d_rad_d = (SQW'(c_xhh_q) << (2 * HW)) + (SQW'(c_xlh_q) << (HW + 1)) + SQW'(c_xll_q)
                 + (SQW'(c_yhh_q) << (2 * HW)) + (SQW'(c_ylh_q) << (HW + 1)) + SQW'(c_yll_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else         d_v_q <= c_v_q;
  end
  always_ff @(posedge clk_i) begin
    d_geo_q <= c_geo_q;
    d_rad_q <= d_rad_d;
  end

  // ---------------- distance root ----------------
  logic                  e_v;
  logic [RW-1:0]         e_s12;
  logic [$bits(geo_t)-1:0] e_side;
  geo_t                  e_geo;

  cci_isqrt #(
    .N      (RW),
    .SIDE_W ($bits(geo_t))
  ) u_sqrt_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_v_q),
    .rad_i   (d_rad_q),
    .side_i  (d_geo_q),
    .valid_o (e_v),
    .root_o  (e_s12),
    .side_o  (e_side)
  );

  assign e_geo = geo_t'(e_side);

  // ---------------- ratio divider, two lanes ----------------
  logic          dv_q   [QW];
  geo_t          dgeo_q [QW];
  logic [RW-1:0] ds_q   [QW];
  logic [NW-1:0] drema_q[QW];
  logic [NW-1:0] dremb_q[QW];
  logic [QW-1:0] dqa_q  [QW];
  logic [QW-1:0] dqb_q  [QW];
  logic          dsa_q  [QW];
  logic          dsb_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic          v_in, sa_in, sb_in, ge_a, ge_b;
    geo_t          geo_in;
    logic [RW-1:0] s_in;
    logic [NW-1:0] ra_in, rb_in;
    logic [QW-1:0] qa_in, qb_in;
    logic [CW-1:0] dsh;

    if (i == 0) begin : g_first
      assign v_in   = e_v;
      assign geo_in = e_geo;
      assign s_in   = e_s12;
      assign ra_in  = {e_geo.ra, {RF{1'b0}}};
      assign rb_in  = {e_geo.rb, {RF{1'b0}}};
      assign qa_in  = '0;
      assign qb_in  = '0;
      // ratio of eight or more saturates
      assign sa_in  = CW'(e_geo.ra) >= (CW'(e_s12) << 3);
      assign sb_in  = CW'(e_geo.rb) >= (CW'(e_s12) << 3);
    end else begin : g_next
      assign v_in   = dv_q[i-1];
      assign geo_in = dgeo_q[i-1];
      assign s_in   = ds_q[i-1];
      assign ra_in  = drema_q[i-1];
      assign rb_in  = dremb_q[i-1];
      assign qa_in  = dqa_q[i-1];
      assign qb_in  = dqb_q[i-1];
      assign sa_in  = dsa_q[i-1];
      assign sb_in  = dsb_q[i-1];
    end

    assign dsh  = CW'(s_in) << (QW - 1 - i);
    assign ge_a = CW'(ra_in) >= dsh;
    assign ge_b = CW'(rb_in) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[i] <= 1'b0;
      else         dv_q[i] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      dgeo_q[i]  <= geo_in;
      ds_q[i]    <= s_in;
      drema_q[i] <= ge_a ? NW'(CW'(ra_in) - dsh) : ra_in;
      dremb_q[i] <= ge_b ? NW'(CW'(rb_in) - dsh) : rb_in;
      dqa_q[i]   <= {qa_in[QW-2:0], ge_a};
      dqb_q[i]   <= {qb_in[QW-2:0], ge_b};
      dsa_q[i]   <= sa_in;
      dsb_q[i]   <= sb_in;
    end
  end

  // ---------------- F: s1 +/- s2 ----------------
  logic               f_v_q;
  ctx_t               f_ctx_q;
  logic [QW-1:0]      f_s1_d, f_s2_d, f_s1_q, f_s2_q;
  logic [QW:0]        f_sum_q;
  logic signed [QW:0] f_diff_q;

  assign f_s1_d = dsa_q[QW-1] ? RATIO_MAX : dqa_q[QW-1];
  assign f_s2_d = dsb_q[QW-1] ? RATIO_MAX : dqb_q[QW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_v_q <= 1'b0;
    else         f_v_q <= dv_q[QW-1];
  end
  always_ff @(posedge clk_i) begin
    f_ctx_q  <= dgeo_q[QW-1].ctx;
    f_s1_q   <= f_s1_d;
    f_s2_q   <= f_s2_d;
    f_sum_q  <= {1'b0, f_s1_d} + {1'b0, f_s2_d};
    f_diff_q <= $signed({1'b0, f_s1_d}) - $signed({1'b0, f_s2_d});
  end

  // ---------------- G: products ----------------
  logic                g_v_q;
  ctx_t                g_ctx_q;
  logic [QW-1:0]       g_s1_q;
  logic signed [PRW-1:0] g_prod_q;
  logic [2*QW-1:0]     g_pss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else         g_v_q <= f_v_q;
  end
  always_ff @(posedge clk_i) begin
    g_ctx_q  <= f_ctx_q;
    g_s1_q   <= f_s1_q;
    g_prod_q <= $signed({1'b0, f_sum_q}) * f_diff_q;
    g_pss_q  <= f_s1_q * f_s2_q;
  end

  // ---------------- H: f and the no-intersection test ----------------
  logic                  h_v_q;
  ctx_t                  h_ctx_q;
  logic [QW-1:0]         h_s1_q;
  logic signed [PRW-1:0] h_vv;
  logic [PRW-1:0]        h_vm;
  logic [FW-1:0]         h_fm;
  logic signed [FW-1:0]  h_f_q;
  logic [FW-1:0]         h_fmag_q;
  logic                  h_fneg_q, h_none_q;
  logic [TW-1:0]         h_thr1_q;

  // f is (prod + 1.0) / 2, truncated toward zero
  assign h_vv = g_prod_q + HALF;
  assign h_vm = h_vv[PRW-1] ? -h_vv : h_vv;
  assign h_fm = h_vm[PRW-1:29];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_v_q <= 1'b0;
    else         h_v_q <= g_v_q;
  end
  always_ff @(posedge clk_i) begin
    h_ctx_q  <= g_ctx_q;
    h_s1_q   <= g_s1_q;
    h_f_q    <= h_vv[PRW-1] ? -$signed(h_fm) : $signed(h_fm);
    h_fmag_q <= h_fm;
    h_fneg_q <= h_vv[PRW-1];
    h_none_q <= h_fm > FW'(g_s1_q);
    h_thr1_q <= g_pss_q[2*QW-1:RF];
  end

  // ---------------- I: (s1+f)(s1-f) ----------------
  logic                 i_v_q;
  ctx_t                 i_ctx_q;
  logic signed [FW-1:0] i_s1s, i_sp, i_sm;
  logic [2*QW+3:0]      i_gprod_q;
  logic                 i_none_q, i_fneg_q;
  logic [FM-1:0]        i_fmag_q;
  logic [TW-1:0]        i_thr1_q;

  assign i_s1s = FW'($signed({1'b0, h_s1_q}));
  assign i_sp  = i_s1s + h_f_q;
  assign i_sm  = i_s1s - h_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_v_q <= 1'b0;
    else         i_v_q <= h_v_q;
  end
  always_ff @(posedge clk_i) begin
    i_ctx_q   <= h_ctx_q;
    i_gprod_q <= i_sp[QW+1:0] * i_sm[QW+1:0];
    i_none_q  <= h_none_q;
    i_fneg_q  <= h_fneg_q;
    i_fmag_q  <= h_fmag_q[FM-1:0];
    i_thr1_q  <= h_thr1_q;
  end

  // ---------------- J: g and threshold ----------------
  logic                      j_v_q;
  pt_t                       j_pt_d, j_pt_q;
  logic [GW-1:0]             j_g_d, j_g_q;
  logic [TW+FACTOR_BITS-1:0] j_tprod;

  assign j_g_d   = i_gprod_q[GW+RF-1:RF];
  assign j_tprod = i_thr1_q * factor_q;

  always_comb begin
    j_pt_d.ctx  = i_ctx_q;
    j_pt_d.none = i_none_q;
    j_pt_d.fneg = i_fneg_q;
    j_pt_d.fmag = i_fmag_q;
    j_pt_d.thr  = j_tprod[TW+FACTOR_BITS-1:FACTOR_BITS];
    j_pt_d.gpos = j_g_d != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) j_v_q <= 1'b0;
    else         j_v_q <= i_v_q;
  end
  always_ff @(posedge clk_i) begin
    j_pt_q <= j_pt_d;
    j_g_q  <= j_g_d;
  end

  // ---------------- root of g ----------------
  logic                   k_in_v;
  logic [N2-1:0]          k_sq;
  logic [$bits(pt_t)-1:0] k_side;
  pt_t                    k_pt;

  cci_isqrt #(
    .N      (N2),
    .SIDE_W ($bits(pt_t))
  ) u_sqrt_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (j_v_q),
    .rad_i   ({j_g_q, {RF{1'b0}}}),
    .side_i  (j_pt_q),
    .valid_o (k_in_v),
    .root_o  (k_sq),
    .side_o  (k_side)
  );

  assign k_pt = pt_t'(k_side);

  // ---------------- K: status and offset partial products ----------------
  // terms: 0 dx*f, 1 dy*sq, 2 dy*f, 3 dx*sq
  logic                 k_v_q;
  sol_t                 k_sol_d, k_sol_q;
  logic signed [CB-1:0] k_ax_q, k_ay_q;
  logic [MW-1:0]        k_am  [4];
  logic [FM-1:0]        k_bm  [4];
  logic                 k_neg [4];
  logic [HW+FM-1:0]     k_pl_q [4];
  logic [UW+FM-1:0]     k_ph_q [4];
  logic                 k_neg_q [4];

  assign k_am[0]  = k_pt.ctx.mx;
  assign k_am[1]  = k_pt.ctx.my;
  assign k_am[2]  = k_pt.ctx.my;
  assign k_am[3]  = k_pt.ctx.mx;
  assign k_bm[0]  = k_pt.fmag;
  assign k_bm[1]  = FM'(k_sq);
  assign k_bm[2]  = k_pt.fmag;
  assign k_bm[3]  = FM'(k_sq);
  assign k_neg[0] = k_pt.ctx.sx ^ k_pt.fneg;
  assign k_neg[1] = k_pt.ctx.sy;
  assign k_neg[2] = k_pt.ctx.sy ^ k_pt.fneg;
  assign k_neg[3] = k_pt.ctx.sx;

  always_comb begin
    k_sol_d.cnt = 2'd0;
    k_sol_d.st  = STATUS_OK;
    if (k_pt.ctx.same) begin
      k_sol_d.st = STATUS_SAME_CENTER;
    end else if (k_pt.none) begin
      k_sol_d.st = STATUS_NO_CROSS;
    end else if (TW'(k_sq) < k_pt.thr) begin
      k_sol_d.st = STATUS_WEAK;
    end else begin
      k_sol_d.cnt = k_pt.gpos ? 2'd2 : 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_v_q <= 1'b0;
    else         k_v_q <= k_in_v;
  end
  always_ff @(posedge clk_i) begin
    k_sol_q <= k_sol_d;
    k_ax_q  <= k_pt.ctx.ax;
    k_ay_q  <= k_pt.ctx.ay;
  end

  for (genvar t = 0; t < 4; t++) begin : g_kterm
    always_ff @(posedge clk_i) begin
      k_pl_q[t]  <= k_am[t][HW-1:0] * k_bm[t];
      k_ph_q[t]  <= k_am[t][MW-1:HW] * k_bm[t];
      k_neg_q[t] <= k_neg[t];
    end
  end

  // ---------------- L: offsets, trunc toward zero, clamp to 2^62 ----------------
  logic                 l_v_q;
  sol_t                 l_sol_q;
  logic signed [CB-1:0] l_ax_q, l_ay_q;
  logic signed [WB-1:0] l_t_q [4];

  for (genvar t = 0; t < 4; t++) begin : g_lterm
    logic [PW-1:0]  full;
    logic [MXW-1:0] mm, mc;
    logic [WB-1:0]  magw;

    assign full = (PW'(k_ph_q[t]) << HW) + PW'(k_pl_q[t]);
    assign mm   = MXW'(full >> RF);
    assign mc   = (mm > LIMU) ? LIMU : mm;
    assign magw = mc[WB-1:0];

    always_ff @(posedge clk_i) begin
      l_t_q[t] <= k_neg_q[t] ? -$signed(magw) : $signed(magw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) l_v_q <= 1'b0;
    else         l_v_q <= k_v_q;
  end
  always_ff @(posedge clk_i) begin
    l_sol_q <= k_sol_q;
    l_ax_q  <= k_ax_q;
    l_ay_q  <= k_ay_q;
  end

  // ---------------- M: base point A + f*d ----------------
  logic                 m_v_q;
  sol_t                 m_sol_q;
  logic signed [WB-1:0] m_bx_q, m_by_q, m_tds_q, m_txs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else         m_v_q <= l_v_q;
  end
  always_ff @(posedge clk_i) begin
    m_sol_q <= l_sol_q;
    m_bx_q  <= sat64(WB'(l_ax_q) + l_t_q[0]);
    m_by_q  <= sat64(WB'(l_ay_q) + l_t_q[2]);
    m_tds_q <= l_t_q[1];
    m_txs_q <= l_t_q[3];
  end

  // ---------------- N: points and output register ----------------
  logic     res_v_q;
  cci_res_t res_d, res_q;

  always_comb begin
    res_d.solution_count = m_sol_q.cnt;
    res_d.status_code    = m_sol_q.st;
    res_d.first_x        = '0;
    res_d.first_y        = '0;
    res_d.second_x       = '0;
    res_d.second_y       = '0;
    if (m_sol_q.cnt != 2'd0) begin
      res_d.first_x = clampc(sat64(m_bx_q - m_tds_q));
      res_d.first_y = clampc(sat64(m_by_q + m_txs_q));
    end
    if (m_sol_q.cnt == 2'd2) begin
      res_d.second_x = clampc(sat64(m_bx_q + m_tds_q));
      res_d.second_y = clampc(sat64(m_by_q - m_txs_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_v_q <= 1'b0;
    else         res_v_q <= m_v_q;
  end
  always_ff @(posedge clk_i) res_q <= res_d;

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // ---------------- assertions ----------------
  a_res_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted transaction");

  a_count_vs_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((res_o.status_code == STATUS_OK) == (res_o.solution_count != 2'd0)))
    else $error("solution count disagrees with status");

  a_unused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.solution_count != 2'd2) |->
      (res_o.second_x == '0 && res_o.second_y == '0))
    else $error("second point not cleared");

endmodule

### rtl/core/cci_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Standalone; used twice by circle_circle_intersection.
module cci_isqrt #(
  parameter int N      = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [2*N-1:0]    rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [N-1:0]      root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q    [N];
  logic [N+1:0]      rem_q  [N];
  logic [N-1:0]      root_q [N];
  logic [2*N-1:0]    x_q    [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic              v_in;
    logic [N+1:0]      rem_in;
    logic [N-1:0]      root_in;
    logic [2*N-1:0]    x_in;
    logic [SIDE_W-1:0] side_in;
    logic [N+1:0]      rem_sh;
    logic [N+1:0]      trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign side_in = side_q[k-1];
    end

    // remainder stays below 2^(k+1) here, so the top bits drop safely
    assign rem_sh = {rem_in[N-1:0], x_in[2*N-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
      root_q[k] <= {root_in[N-2:0], ge};
      x_q[k]    <= x_in << 2;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule
